// ===== rtl/tole_pkg.sv =====
`default_nettype none
package tole_pkg;
  localparam int NUM_TAGS_DEF      = 10;
  localparam int SLOTS_PER_TAG_DEF = 256;

  localparam int OP_W   = 3;
  localparam int TAG_W  = 4;
  localparam int ID_W   = 29;
  localparam int RIDX_W = 8;
  localparam int ST_W   = 3;

  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_ALL  = 3'd2;
  localparam logic [OP_W-1:0] OP_MV_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_MV_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_CPY_NEXT = 3'd5;
  localparam logic [OP_W-1:0] OP_MV_NEXT  = 3'd6;
  localparam logic [OP_W-1:0] OP_READ     = 3'd7;

  localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EDGE      = 3'd4;
endpackage
`default_nettype wire

// ===== rtl/tole_if.sv =====
`default_nettype none
interface tole_in_if import tole_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TAG_W-1:0]  tag;
  logic [ID_W-1:0]   item_id;
  logic [RIDX_W-1:0] read_index;
  modport source (output valid, op, tag, item_id, read_index, input ready);
  modport sink (input valid, op, tag, item_id, read_index, output ready);
endinterface

interface tole_out_if import tole_pkg::*; #(
  parameter int CNT_W = $clog2(SLOTS_PER_TAG_DEF + 1)
) ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  read_value;
  modport source (output valid, status, count, read_value, input ready);
  modport sink (input valid, status, count, read_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/tole_ram.sv =====
`default_nettype none
module tole_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 2560
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/tagged_ordered_list_engine.sv =====
// Channel   Dir  Fields                                Handshake
// in_ch     in   op, tag, item_id, read_index          valid/ready
// out_ch    out  status, count, read_value             valid/ready
//
// One word is worked on at a time; in_ch.ready is high only when idle.
// Each list position visited is read from the store, then compared or written.
// A remove searches its list and then compacts it; move-next works on two lists
// (an add to the next tag, then a remove from this one), and remove-from-all-tags
// does a remove on each of the NUM_TAGS lists in turn.
// Reset (rst_n low, synchronous) zeroes every count; the store needs no clearing.
// A result waiting on out_ch does not stop the next word being taken.
`default_nettype none
module tagged_ordered_list_engine import tole_pkg::*; #(
  parameter int NUM_TAGS      = NUM_TAGS_DEF,
  parameter int SLOTS_PER_TAG = SLOTS_PER_TAG_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  tole_in_if.sink  in_ch,
  tole_out_if.source out_ch
);
  localparam int CNT_W  = $clog2(SLOTS_PER_TAG + 1);
  localparam int TIDX_W = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
  localparam int DEPTH  = NUM_TAGS * SLOTS_PER_TAG;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = CNT_W + RIDX_W;
  localparam logic [ADDR_W-1:0] SLOTS_A = ADDR_W'(SLOTS_PER_TAG);
  localparam logic [CNT_W-1:0]  SLOTS_C = CNT_W'(SLOTS_PER_TAG);
  localparam logic [TIDX_W-1:0] LAST_T  = TIDX_W'(NUM_TAGS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_CHK, S_RD_WAIT, S_LOC_RD, S_LOC_CMP, S_DECIDE, S_DROP_RD,
    S_DROP_WR, S_REM_END, S_SWAP_WA, S_SWAP_WB, S_FIN
  } state_t;
  typedef enum logic [1:0] {M_ADD, M_REM, M_SWAP} mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [TIDX_W-1:0] tag_r, tag_nxt, cur_r, cur_nxt;
  logic [ID_W-1:0]   id_r, id_nxt, value_r, value_nxt;
  logic [RIDX_W-1:0] ridx_r, ridx_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt, pos_r, pos_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic found_r, found_nxt, any_r, any_nxt, bad_r, bad_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_st_r, out_st_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [ID_W-1:0]  out_val_r, out_val_nxt;
  logic [CNT_W-1:0] cnt_r [NUM_TAGS];
  logic [CNT_W-1:0] cur_cnt, cnt_wval;
  logic             cnt_we;
  logic             we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ID_W-1:0]   wdata, rdata;
  logic [CNT_W-1:0]  nb;
  logic [ST_W-1:0]   st_add;
  logic [TIDX_W-1:0] in_tag, in_next;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [TIDX_W-1:0] t,
                                                 input logic [CNT_W-1:0] p);
    return ADDR_W'(t) * SLOTS_A + ADDR_W'(p);
  endfunction

  tole_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cur_cnt = cnt_r[cur_r];
  assign in_tag  = TIDX_W'(in_ch.tag);
  assign in_next = (in_tag == LAST_T) ? '0 : TIDX_W'(in_tag + 1'b1);
  assign nb      = (op_r == OP_MV_FRONT) ? pos_r - 1'b1 : pos_r + 1'b1;
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.count      = out_cnt_r;
  assign out_ch.read_value = out_val_r;

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r; op_nxt = op_r; tag_nxt = tag_r;
    cur_nxt = cur_r; id_nxt = id_r; value_nxt = value_r; ridx_nxt = ridx_r;
    k_nxt = k_r; pos_nxt = pos_r; st_nxt = st_r; found_nxt = found_r;
    any_nxt = any_r; bad_nxt = bad_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt = out_st_r; out_cnt_nxt = out_cnt_r; out_val_nxt = out_val_r;
    we = 1'b0; waddr = addr_of(cur_r, k_r); wdata = id_r; raddr = addr_of(cur_r, k_r);
    cnt_we = 1'b0; cnt_wval = cur_cnt;
    st_add = ST_DONE;
    case (state_r)
      S_IDLE: if (in_ch.valid) begin
        op_nxt = in_ch.op; id_nxt = in_ch.item_id; ridx_nxt = in_ch.read_index;
        tag_nxt = in_tag; value_nxt = '0; any_nxt = 1'b0; k_nxt = '0;
        st_nxt = ST_DONE; cur_nxt = in_tag; bad_nxt = 1'b0; state_nxt = S_LOC_RD;
        if ({1'b0, in_ch.tag} >= (TAG_W + 1)'(NUM_TAGS)) begin
          bad_nxt = 1'b1; st_nxt = ST_EDGE; cur_nxt = '0; tag_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          case (in_ch.op)
            OP_ADD: mode_nxt = M_ADD;
            OP_REMOVE: mode_nxt = M_REM;
            OP_REM_ALL: begin
              mode_nxt = M_REM; cur_nxt = '0;
            end
            OP_MV_FRONT, OP_MV_BACK: mode_nxt = M_SWAP;
            OP_CPY_NEXT, OP_MV_NEXT: begin
              mode_nxt = M_ADD; cur_nxt = in_next;
            end
            default: state_nxt = S_RD_CHK;
          endcase
        end
      end
      S_RD_CHK: begin
        if (CMP_W'(ridx_r) < CMP_W'(cur_cnt)) begin
          raddr = addr_of(cur_r, CNT_W'(ridx_r));
          state_nxt = S_RD_WAIT;
        end else begin
          st_nxt = ST_EDGE; state_nxt = S_FIN;
        end
      end
      S_RD_WAIT: begin
        value_nxt = rdata; state_nxt = S_FIN;
      end
      S_LOC_RD: begin
        if (k_r >= cur_cnt) begin
          found_nxt = 1'b0; state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_LOC_CMP;
        end
      end
      S_LOC_CMP: begin
        if (rdata == id_r) begin
          found_nxt = 1'b1; pos_nxt = k_r; state_nxt = S_DECIDE;
        end else begin
          k_nxt = k_r + 1'b1; state_nxt = S_LOC_RD;
        end
      end
      S_DECIDE: begin
        case (mode_r)
          M_ADD: begin
            if (found_r) st_add = ST_PRESENT;
            else if (cur_cnt >= SLOTS_C) st_add = ST_FULL;
            else begin
              we = 1'b1; waddr = addr_of(cur_r, cur_cnt);
              cnt_we = 1'b1; cnt_wval = cur_cnt + 1'b1;
            end
            cur_nxt = tag_r;
            if (op_r == OP_MV_NEXT && st_add != ST_FULL) begin
              mode_nxt = M_REM; k_nxt = '0; state_nxt = S_LOC_RD;
            end else begin
              st_nxt = st_add; state_nxt = S_FIN;
            end
          end
          M_REM: begin
            if (found_r) begin
              k_nxt = pos_r; state_nxt = S_DROP_RD;
            end else begin
              state_nxt = S_REM_END;
            end
          end
          default: begin
            if (!found_r) begin
              st_nxt = ST_NOT_FOUND; state_nxt = S_FIN;
            end else if ((op_r == OP_MV_FRONT) ? (pos_r == '0)
                                               : (pos_r + 1'b1 == cur_cnt)) begin
              st_nxt = ST_EDGE; state_nxt = S_FIN;
            end else begin
              raddr = addr_of(cur_r, nb); state_nxt = S_SWAP_WA;
            end
          end
        endcase
      end
      S_DROP_RD: begin
        if (k_r + 1'b1 >= cur_cnt) begin
          cnt_we = 1'b1; cnt_wval = cur_cnt - 1'b1; state_nxt = S_REM_END;
        end else begin
          raddr = addr_of(cur_r, k_r + 1'b1); state_nxt = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        // shift the later entry down one place
        we = 1'b1; wdata = rdata; k_nxt = k_r + 1'b1; state_nxt = S_DROP_RD;
      end
      S_REM_END: begin
        if (op_r == OP_REM_ALL && cur_r != LAST_T) begin
          any_nxt = any_r || found_r; cur_nxt = cur_r + 1'b1; k_nxt = '0;
          state_nxt = S_LOC_RD;
        end else begin
          st_nxt = (found_r || (op_r == OP_REM_ALL && any_r)) ? ST_DONE : ST_NOT_FOUND;
          cur_nxt = tag_r; state_nxt = S_FIN;
        end
      end
      S_SWAP_WA: begin
        we = 1'b1; waddr = addr_of(cur_r, pos_r); wdata = rdata; state_nxt = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        we = 1'b1; waddr = addr_of(cur_r, nb); state_nxt = S_FIN;
      end
      S_FIN: if (!out_valid_r || out_ch.ready) begin
        out_valid_nxt = 1'b1; out_st_nxt = st_r;
        out_cnt_nxt = bad_r ? '0 : cur_cnt; out_val_nxt = value_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TAGS; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
      if (cnt_we) cnt_r[cur_r] <= cnt_wval;
    end
    mode_r <= mode_nxt; op_r <= op_nxt; tag_r <= tag_nxt; cur_r <= cur_nxt;
    id_r <= id_nxt; value_r <= value_nxt; ridx_r <= ridx_nxt; k_r <= k_nxt;
    pos_r <= pos_nxt; st_r <= st_nxt; found_r <= found_nxt; any_r <= any_nxt;
    bad_r <= bad_nxt; out_st_r <= out_st_nxt; out_cnt_r <= out_cnt_nxt;
    out_val_r <= out_val_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> cnt_wval <= SLOTS_C) else $error("list count beyond capacity");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !we) else $error("store written outside work");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("second word taken while busy");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN)) else $error("result raised outside finish");
endmodule
`default_nettype wire
